[sv/mmf_pkg.sv]
`default_nettype none

package mmf_pkg;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] REQ_BYTE     = 2'd0;
    localparam logic [1:0] REQ_ACK_NOTE = 2'd1;
    localparam logic [1:0] REQ_ACK_CTRL = 2'd2;

    // Status byte values and ranges that the filter recognizes.
    localparam logic [7:0] STATUS_MIN      = 8'h80;
    localparam logic [7:0] NOTE_OFF_LO     = 8'h80;
    localparam logic [7:0] NOTE_OFF_HI     = 8'h85;
    localparam logic [7:0] NOTE_OFF_SKIP   = 8'h84;
    localparam logic [7:0] NOTE_ON_LO      = 8'h90;
    localparam logic [7:0] NOTE_ON_HI      = 8'h95;
    localparam logic [7:0] NOTE_HOLD       = 8'h94;
    localparam logic [7:0] CTRL_LO         = 8'hB0;
    localparam logic [7:0] CTRL_HI         = 8'hB5;
    localparam logic [7:0] CTRL_POT_LOW    = 8'hB4;
    localparam logic [7:0] CTRL_POT_HIGH   = 8'hB5;
    localparam logic [6:0] POT_GRP1_MAX    = 7'h05;
    localparam logic [6:0] POT_GRP2_MAX    = 7'h08;

    // Potentiometer event groups.
    localparam logic [1:0] POT_NONE = 2'd0;
    localparam logic [1:0] POT_GRP1 = 2'd1;
    localparam logic [1:0] POT_GRP2 = 2'd2;
    localparam logic [1:0] POT_GRP3 = 2'd3;

    // Command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    localparam int unsigned OUT_DATA_W = 56;

    // Operations that the front hands to the back.
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_ACK_NOTE = 3'd1,
        CMD_ACK_CTRL = 3'd2,
        CMD_NOTE     = 3'd3,
        CMD_HOLD     = 3'd4,
        CMD_CTRL     = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [1:0] pot_group;
        logic       ctrl_pend;
    } cmd_t;

    // Queue handshake toward the back.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

endpackage

`default_nettype wire

[sv/midi_message_filter_top.sv]
`default_nettype none

// MIDI message filter. Each request on the s_ stream is a received MIDI byte or
// an acknowledge of the note or control flag, and each request yields exactly one
// result on the m_ stream showing the flags and stored message fields after that
// request, plus any potentiometer event it raised. The block sustains one request
// per clock while the m_ stream takes results; a result passes from the command
// queue into the output register before it appears on the m_ stream. A two-entry
// command queue between the parser and the message state lets the input keep
// flowing for two requests while the output stalls.

module midi_message_filter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] note_flag, [7:1] note_number, [14:8] note_velocity, [21:15] held_note,
    // [22] control_flag, [29:23] control_number, [36:30] ctrl_value,
    // [38:37] pot_group, [45:39] pot_number, [52:46] pot_value, [55:53] zero
    output logic [55:0]      m_tdata
);

    logic                queue_full;
    logic                push;
    mmf_pkg::cmd_t       push_cmd;
    logic                pop;
    mmf_pkg::queue_out_t head;

    mmf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mmf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head)
    );

    mmf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[sv/mmf_front.sv]
`default_nettype none

module mmf_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         queue_full,
    output logic              push,
    output mmf_pkg::cmd_t     push_cmd
);

    logic       byte_count_reg, byte_count_next;
    logic [7:0] status_reg, status_next;
    logic [6:0] first_data_reg, first_data_next;

    logic       accept;
    logic       note_range;
    logic       ctrl_range;
    logic [6:0] rx_low;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;
    assign rx_low   = s_tdata[6:0];

    // Status ranges of the stored running status.
    assign note_range = ((status_reg >= mmf_pkg::NOTE_ON_LO) &&
                         (status_reg <= mmf_pkg::NOTE_ON_HI)) ||
                        ((status_reg >= mmf_pkg::NOTE_OFF_LO) &&
                         (status_reg <= mmf_pkg::NOTE_OFF_HI));
    assign ctrl_range = (status_reg >= mmf_pkg::CTRL_LO) &&
                        (status_reg <= mmf_pkg::CTRL_HI);

    // Byte parser and message classification.
    always_comb begin
        byte_count_next    = byte_count_reg;
        status_next        = status_reg;
        first_data_next    = first_data_reg;
        push_cmd.kind      = mmf_pkg::CMD_NONE;
        push_cmd.d1        = first_data_reg;
        push_cmd.d2        = rx_low;
        push_cmd.pot_group = mmf_pkg::POT_NONE;
        push_cmd.ctrl_pend = 1'b1;

        case (s_tuser)
            mmf_pkg::REQ_BYTE: begin
                if (s_tdata >= mmf_pkg::STATUS_MIN) begin
                    byte_count_next = 1'b0;
                    status_next     = s_tdata;
                end else if (!byte_count_reg) begin
                    byte_count_next = 1'b1;
                    first_data_next = rx_low;
                end else begin
                    // Second data byte: judge the full message.
                    byte_count_next = 1'b0;
                    if (note_range) begin
                        if (status_reg == mmf_pkg::NOTE_HOLD) begin
                            push_cmd.kind = mmf_pkg::CMD_HOLD;
                        end else if (status_reg != mmf_pkg::NOTE_OFF_SKIP) begin
                            push_cmd.kind = mmf_pkg::CMD_NOTE;
                        end
                    end else if (ctrl_range) begin
                        push_cmd.kind = mmf_pkg::CMD_CTRL;
                        if (status_reg == mmf_pkg::CTRL_POT_LOW) begin
                            push_cmd.ctrl_pend = 1'b0;
                            if (first_data_reg <= mmf_pkg::POT_GRP1_MAX) begin
                                push_cmd.pot_group = mmf_pkg::POT_GRP1;
                            end else if (first_data_reg <= mmf_pkg::POT_GRP2_MAX) begin
                                push_cmd.pot_group = mmf_pkg::POT_GRP2;
                            end
                        end
                        if (status_reg == mmf_pkg::CTRL_POT_HIGH) begin
                            push_cmd.ctrl_pend = 1'b0;
                            push_cmd.pot_group = mmf_pkg::POT_GRP3;
                        end
                    end
                end
            end
            mmf_pkg::REQ_ACK_NOTE: begin
                push_cmd.kind = mmf_pkg::CMD_ACK_NOTE;
            end
            mmf_pkg::REQ_ACK_CTRL: begin
                push_cmd.kind = mmf_pkg::CMD_ACK_CTRL;
            end
            default: begin
                push_cmd.kind = mmf_pkg::CMD_NONE;
            end
        endcase
    end

    // Parser state updates only on an accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 1'b0;
            status_reg     <= 8'd0;
            first_data_reg <= 7'd0;
        end else if (accept) begin
            byte_count_reg <= byte_count_next;
            status_reg     <= status_next;
            first_data_reg <= first_data_next;
        end
    end

endmodule

`default_nettype wire

[sv/mmf_queue.sv]
`default_nettype none

module mmf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire mmf_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output mmf_pkg::queue_out_t head
);

    mmf_pkg::cmd_t entries_reg [mmf_pkg::QUEUE_DEPTH];

    logic [mmf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mmf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mmf_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == mmf_pkg::QUEUE_CNT_W'(mmf_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entries_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head.valid;

    // Pointer and fill count bookkeeping.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/mmf_back.sv]
`default_nettype none

module mmf_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire mmf_pkg::queue_out_t              head,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mmf_pkg::OUT_DATA_W-1:0]        m_tdata
);

    logic       note_pending_reg, note_pending_next;
    logic [6:0] stored_note_reg, stored_note_next;
    logic [6:0] stored_velocity_reg, stored_velocity_next;
    logic [6:0] latched_note_reg, latched_note_next;
    logic       control_pending_reg, control_pending_next;
    logic [6:0] stored_controller_reg, stored_controller_next;
    logic [6:0] stored_value_reg, stored_value_next;

    logic [1:0] pot_group_next;
    logic [6:0] pot_number_next;
    logic [6:0] pot_value_next;

    logic                           out_valid_reg;
    logic [mmf_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    assign pop      = head.valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Apply the command at the head of the queue to the message state.
    always_comb begin
        note_pending_next      = note_pending_reg;
        stored_note_next       = stored_note_reg;
        stored_velocity_next   = stored_velocity_reg;
        latched_note_next      = latched_note_reg;
        control_pending_next   = control_pending_reg;
        stored_controller_next = stored_controller_reg;
        stored_value_next      = stored_value_reg;
        pot_group_next         = mmf_pkg::POT_NONE;
        pot_number_next        = 7'd0;
        pot_value_next         = 7'd0;

        case (head.cmd.kind)
            mmf_pkg::CMD_ACK_NOTE: begin
                note_pending_next = 1'b0;
            end
            mmf_pkg::CMD_ACK_CTRL: begin
                control_pending_next = 1'b0;
            end
            mmf_pkg::CMD_NOTE: begin
                note_pending_next    = 1'b1;
                stored_note_next     = head.cmd.d1;
                stored_velocity_next = head.cmd.d2;
                latched_note_next    = 7'd0;
            end
            mmf_pkg::CMD_HOLD: begin
                // A held note is latched only while none is held.
                if (latched_note_reg == 7'd0) begin
                    note_pending_next = 1'b1;
                    latched_note_next = head.cmd.d1;
                end
            end
            mmf_pkg::CMD_CTRL: begin
                control_pending_next   = head.cmd.ctrl_pend;
                stored_controller_next = head.cmd.d1;
                stored_value_next      = head.cmd.d2;
                pot_group_next         = head.cmd.pot_group;
                if (head.cmd.pot_group != mmf_pkg::POT_NONE) begin
                    pot_number_next = head.cmd.d1;
                    pot_value_next  = head.cmd.d2;
                end
            end
            default: begin
                pot_group_next = mmf_pkg::POT_NONE;
            end
        endcase

        out_data_next = {3'b000, pot_value_next, pot_number_next, pot_group_next,
                         stored_value_next, stored_controller_next,
                         control_pending_next, latched_note_next,
                         stored_velocity_next, stored_note_next, note_pending_next};
    end

    // Message state and output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_pending_reg      <= 1'b0;
            stored_note_reg       <= 7'd0;
            stored_velocity_reg   <= 7'd0;
            latched_note_reg      <= 7'd0;
            control_pending_reg   <= 1'b0;
            stored_controller_reg <= 7'd0;
            stored_value_reg      <= 7'd0;
            out_valid_reg         <= 1'b0;
        end else begin
            if (pop) begin
                note_pending_reg      <= note_pending_next;
                stored_note_reg       <= stored_note_next;
                stored_velocity_reg   <= stored_velocity_next;
                latched_note_reg      <= latched_note_next;
                control_pending_reg   <= control_pending_next;
                stored_controller_reg <= stored_controller_next;
                stored_value_reg      <= stored_value_next;
                out_valid_reg         <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
